// File: sv/vxarp_pkg.sv
package vxarp_pkg;

  // Frame offsets, 20-byte outer IPv4 header assumed
  localparam int unsigned OffsetW = 7;

  typedef logic [OffsetW-1:0] offset_t;

  localparam offset_t OffEthTypeHi   = offset_t'(12);
  localparam offset_t OffEthTypeLo   = offset_t'(13);
  localparam offset_t OffIpProto     = offset_t'(23);
  localparam offset_t OffVtepFirst   = offset_t'(26);
  localparam offset_t OffVtepLast    = offset_t'(29);
  localparam offset_t OffUdpDportHi  = offset_t'(36);
  localparam offset_t OffUdpDportLo  = offset_t'(37);
  localparam offset_t OffVniFirst    = offset_t'(46);
  localparam offset_t OffVniLast     = offset_t'(48);
  localparam offset_t OffInnerTypeHi = offset_t'(62);
  localparam offset_t OffInnerTypeLo = offset_t'(63);
  localparam offset_t OffArpOpHi     = offset_t'(70);
  localparam offset_t OffArpOpLo     = offset_t'(71);
  localparam offset_t OffMacFirst    = offset_t'(72);
  localparam offset_t OffMacLast     = offset_t'(77);
  localparam offset_t OffSipFirst    = offset_t'(78);
  localparam offset_t OffSipLast     = offset_t'(81);
  localparam offset_t OffEmit        = offset_t'(91);
  localparam offset_t OffLimit       = offset_t'(92);

  localparam int unsigned MacBytes = 6;

  // Expected header bytes
  localparam logic [7:0] EthTypeIpv4Hi = 8'h08;
  localparam logic [7:0] EthTypeIpv4Lo = 8'h00;
  localparam logic [7:0] IpProtoUdp    = 8'd17;
  localparam logic [7:0] EthTypeArpHi  = 8'h08;
  localparam logic [7:0] EthTypeArpLo  = 8'h06;
  localparam logic [7:0] ArpOpReqHi    = 8'h00;
  localparam logic [7:0] ArpOpReqLo    = 8'h01;

  localparam logic [15:0] VxlanPortReset = 16'd4789;

  // One snooped ARP request
  typedef struct packed {
    logic [23:0] vni;
    logic [31:0] vtep_ip;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
  } result_t;

  // Input register to parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } beat_t;

endpackage

// File: sv/vxarp_in_reg.sv
module vxarp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_end_i,
  input  logic              consume_i,
  output vxarp_pkg::beat_t  beat_o
);
  import vxarp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  // Take a new beat when empty or when the held one drains this cycle
  assign in_stall_o = valid_q && !consume_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_byte_i;
      last_q <= frame_end_i;
    end
  end

  assign beat_o = '{valid: valid_q, data: data_q, last: last_q};

endmodule

// File: sv/vxarp_parser.sv
module vxarp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vxarp_pkg::beat_t    beat_i,
  input  logic [15:0]         udp_port_i,
  input  logic                out_ready_i,
  output logic                consume_o,
  output logic                evt_valid_o,
  output vxarp_pkg::result_t  evt_o
);
  import vxarp_pkg::*;

  offset_t     offset_q, offset_d;
  logic        match_q, match_d;
  logic [23:0] vni_q, vni_d;
  logic [31:0] vtep_q, vtep_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] sip_q, sip_d;
  logic        in_range;
  logic        byte_ok;
  logic        hit;
  logic [7:0]  b;

  assign b        = beat_i.data;
  assign in_range = offset_q < OffLimit;

  // Per-offset header check
  always_comb begin
    byte_ok = 1'b1;
    case (offset_q)
      OffEthTypeHi:   byte_ok = (b == EthTypeIpv4Hi);
      OffEthTypeLo:   byte_ok = (b == EthTypeIpv4Lo);
      OffIpProto:     byte_ok = (b == IpProtoUdp);
      OffUdpDportHi:  byte_ok = (b == udp_port_i[15:8]);
      OffUdpDportLo:  byte_ok = (b == udp_port_i[7:0]);
      OffInnerTypeHi: byte_ok = (b == EthTypeArpHi);
      OffInnerTypeLo: byte_ok = (b == EthTypeArpLo);
      OffArpOpHi:     byte_ok = (b == ArpOpReqHi);
      OffArpOpLo:     byte_ok = (b == ArpOpReqLo);
      default:        byte_ok = 1'b1;
    endcase
  end

  // Event on the emit byte; it waits when the result register is full
  assign hit         = beat_i.valid && (offset_q == OffEmit) && match_q;
  assign consume_o   = beat_i.valid && (!hit || out_ready_i);
  assign evt_valid_o = hit && out_ready_i;
  assign evt_o       = '{vni: vni_q, vtep_ip: vtep_q, sender_mac: mac_q, sender_ip: sip_q};

  // Offset, match flag and field captures
  always_comb begin
    offset_d = offset_q;
    match_d  = match_q;
    vni_d    = vni_q;
    vtep_d   = vtep_q;
    mac_d    = mac_q;
    sip_d    = sip_q;
    if (consume_o) begin
      if (in_range) begin
        if (!byte_ok) begin
          match_d = 1'b0;
        end
        if (offset_q >= OffVtepFirst && offset_q <= OffVtepLast) begin
          vtep_d = {vtep_q[23:0], b};
        end else if (offset_q >= OffVniFirst && offset_q <= OffVniLast) begin
          vni_d = {vni_q[15:0], b};
        end else if (offset_q >= OffSipFirst && offset_q <= OffSipLast) begin
          sip_d = {sip_q[23:0], b};
        end
        // MAC bytes land first-byte-low
        for (int k = 0; k < MacBytes; k++) begin
          if (offset_q == OffMacFirst + offset_t'(k)) begin
            mac_d[8*k +: 8] = b;
          end
        end
        offset_d = offset_q + offset_t'(1);
      end
      if (beat_i.last) begin
        offset_d = '0;
        match_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      match_q  <= 1'b1;
      vni_q    <= '0;
      vtep_q   <= '0;
      mac_q    <= '0;
      sip_q    <= '0;
    end else begin
      offset_q <= offset_d;
      match_q  <= match_d;
      vni_q    <= vni_d;
      vtep_q   <= vtep_d;
      mac_q    <= mac_d;
      sip_q    <= sip_d;
    end
  end

endmodule

// File: sv/vxarp_out_reg.sv
module vxarp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_valid_i,
  input  vxarp_pkg::result_t  evt_i,
  output logic                out_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vxarp_pkg::result_t  res_o
);
  import vxarp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held beat leaves this cycle
  assign out_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (evt_valid_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_valid_i) begin
      res_q <= evt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/vxlan_arp_request_snooper.sv
// VXLAN ARP request snooper. Frames enter one byte per beat, with frame_end_i
// on the last byte; one byte is taken every cycle while the result side keeps
// up. A byte goes into an input register and is checked and captured by the
// offset parser in the next cycle. A match is written into the result register
// at the end of that same cycle when that register has room; a result for
// byte 91 passes through the input register and then the result register.
// The parser checks outer ethertype IPv4, IP protocol UDP (20-byte IP header
// assumed), the UDP destination port against the configured VXLAN port,
// inner ethertype ARP and ARP opcode request, and reports VNI, outer source
// IP, sender MAC (first wire byte in bits 7:0) and sender IP. Only the byte-91
// beat can wait on a full result register. The port register resets to 4789
// and should be written only while no frame is in flight.
module vxlan_arp_request_snooper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] vni_o,
  output logic [31:0] vtep_ip_o,
  output logic [47:0] sender_mac_o,
  output logic [31:0] sender_ip_o
);
  import vxarp_pkg::*;

  logic [15:0] port_q;
  beat_t       beat;
  logic        consume;
  logic        out_ready;
  logic        evt_valid;
  result_t     evt;
  result_t     res;

  // VXLAN port register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= VxlanPortReset;
    end else if (cfg_we_i) begin
      port_q <= cfg_wdata_i;
    end
  end

  vxarp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .consume_i   (consume),
    .beat_o      (beat)
  );

  vxarp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .udp_port_i  (port_q),
    .out_ready_i (out_ready),
    .consume_o   (consume),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  vxarp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_valid),
    .evt_i       (evt),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign vni_o        = res.vni;
  assign vtep_ip_o    = res.vtep_ip;
  assign sender_mac_o = res.sender_mac;
  assign sender_ip_o  = res.sender_ip;

endmodule
